FILE: hw/rtl/jsr_pkg.sv
// ---------------------------------------------------------------------------
// jsr_pkg
// shared constants, register indexes, region codes and the queue item type
// of the jacobi stencil region stream unit
// ---------------------------------------------------------------------------
package jsr_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int DIM_W       = 11;
  localparam int HALO_W      = 9;
  localparam int REGION_W    = 2;
  localparam int DATA_W      = 32;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALO_WIDTH    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_SELECT = 8'd3;

  localparam logic [REGION_W-1:0] REGION_INTERIOR = 2'd0;
  localparam logic [REGION_W-1:0] REGION_BAND     = 2'd1;
  localparam logic [REGION_W-1:0] REGION_BOTH     = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] cell_value;
    logic [COL_W-1:0]         col;
    logic [COL_W-1:0]         next_col;
    logic [ROW_W-1:0]         row;
    logic                     take;
    logic                     last;
  } jsr_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } jsr_qstat_t;

endpackage

FILE: hw/rtl/jsr_if.sv
// ---------------------------------------------------------------------------
// jsr channel interfaces
// valid/ready channels for cells in, results out and register writes
// ---------------------------------------------------------------------------
interface jsr_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [jsr_pkg::DATA_W-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink (input valid, input cell_value, output ready);
endinterface

interface jsr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [jsr_pkg::DATA_W-1:0] result_value;
  logic [jsr_pkg::ROW_W-1:0]         row_index;
  logic [jsr_pkg::COL_W-1:0]         col_index;
  logic                              last_of_frame;

  modport source (output valid, output result_value, output row_index, output col_index,
                  output last_of_frame, input ready);
  modport sink (input valid, input result_value, input row_index, input col_index,
                input last_of_frame, output ready);
endinterface

interface jsr_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [jsr_pkg::CFG_IDX_W-1:0]      index;
  logic [jsr_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/jacobi_stencil_region_stream_unit.sv
// ---------------------------------------------------------------------------
// jacobi_stencil_region_stream_unit
// streaming four-point jacobi update of one tile in signed q16.16
// ---------------------------------------------------------------------------
// Cells enter in raster order, one per clock for as long as results are
// taken: each cell costs one write and one read on each of the two line
// stores, which have one port of each kind, so that port pair sets the
// figure of one cell per cycle. A result for a cell is offered once the
// cell directly below it has passed the queue, the stage registers and the
// output register; a small queue between the classifying front end and the
// line store back end absorbs output stalls. Line stores are not cleared
// after reset and need no start-up pass. Any write to a defined register
// restarts the tile at row 0, column 0 and is meant for idle periods only.
module jacobi_stencil_region_stream_unit (
  input  logic      clk,
  input  logic      rst_n,
  jsr_in_if.sink    in_chan,
  jsr_out_if.source out_chan,
  jsr_cfg_if.sink   cfg_chan
);

  jsr_pkg::jsr_item_t  push_item, pop_item;
  jsr_pkg::jsr_qstat_t q_stat;
  logic                q_push, q_pop;

  jsr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_chan (cfg_chan),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  jsr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .stat      (q_stat)
  );

  jsr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .q_item   (pop_item),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

  // no transaction is pushed into a full queue
  assert property (@(posedge clk) disable iff (!rst_n) q_stat.full |-> !q_push)
    else $error("queue overflow");

  // back end never pops an empty queue
  assert property (@(posedge clk) disable iff (!rst_n) q_stat.empty |-> !q_pop)
    else $error("queue underflow");

  // a push into an empty queue leaves it non-empty on the next edge
  assert property (@(posedge clk) disable iff (!rst_n)
                   (q_stat.empty && q_push) |=> !q_stat.empty)
    else $error("queue lost a transaction");

endmodule

FILE: hw/rtl/jsr_ram.sv
// ---------------------------------------------------------------------------
// jsr_ram
// simple dual-port ram, one write and one registered read port, read-first
// ---------------------------------------------------------------------------
module jsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

endmodule

FILE: hw/rtl/jsr_front.sv
// ---------------------------------------------------------------------------
// jsr_front
// register file, raster position counters and per-cell classification
// ---------------------------------------------------------------------------
module jsr_front (
  input  logic               clk,
  input  logic               rst_n,
  jsr_in_if.sink             in_chan,
  jsr_cfg_if.sink            cfg_chan,
  input  jsr_pkg::jsr_qstat_t q_stat,
  output logic               q_push,
  output jsr_pkg::jsr_item_t  q_item
);

  logic [jsr_pkg::DIM_W-1:0]    grid_width_r, grid_width_nxt;
  logic [jsr_pkg::DIM_W-1:0]    grid_height_r, grid_height_nxt;
  logic [jsr_pkg::HALO_W-1:0]   halo_width_r, halo_width_nxt;
  logic [jsr_pkg::REGION_W-1:0] region_r, region_nxt;
  logic [jsr_pkg::ROW_W-1:0]    row_r, row_nxt;
  logic [jsr_pkg::COL_W-1:0]    col_r, col_nxt;

  logic [jsr_pkg::DIM_W-1:0]    w_eff, h_eff;
  logic [jsr_pkg::HALO_W-1:0]   halo_eff;
  logic [jsr_pkg::HALO_W:0]     band;
  logic [jsr_pkg::DIM_W-1:0]    halo_d, band_d;
  logic [jsr_pkg::DIM_W-1:0]    w_m_halo, h_m_halo, w_m_band, h_m_band;
  logic [jsr_pkg::ROW_W-1:0]    tr;
  logic [jsr_pkg::DIM_W-1:0]    tr_d, col_d, last_row, last_col;
  logic [jsr_pkg::DIM_W-1:0]    col_inc, row_inc;
  logic [jsr_pkg::COL_W-1:0]    col_step;
  logic [jsr_pkg::ROW_W-1:0]    row_step;
  logic                         col_wrap;
  logic                         geom_ok, in_core, in_band, sel_ok;
  logic                         accept, cfg_wr, cfg_hit;

  assign accept        = in_chan.valid & in_chan.ready;
  assign in_chan.ready = ~q_stat.full;
  assign cfg_chan.ready = 1'b1;
  assign cfg_wr        = cfg_chan.valid & cfg_chan.ready;
  assign q_push        = accept;

  // dimensions as used
  always_comb begin
    if (grid_width_r == '0) begin
      w_eff = jsr_pkg::DIM_W'(1);
    end else if (grid_width_r > jsr_pkg::DIM_W'(jsr_pkg::MAX_WIDTH)) begin
      w_eff = jsr_pkg::DIM_W'(jsr_pkg::MAX_WIDTH);
    end else begin
      w_eff = grid_width_r;
    end
    if (grid_height_r == '0) begin
      h_eff = jsr_pkg::DIM_W'(1);
    end else if (grid_height_r > jsr_pkg::DIM_W'(jsr_pkg::MAX_HEIGHT)) begin
      h_eff = jsr_pkg::DIM_W'(jsr_pkg::MAX_HEIGHT);
    end else begin
      h_eff = grid_height_r;
    end
    halo_eff = (halo_width_r == '0) ? jsr_pkg::HALO_W'(1) : halo_width_r;
  end

  assign band     = {halo_eff, 1'b0};
  assign halo_d   = jsr_pkg::DIM_W'(halo_eff);
  assign band_d   = jsr_pkg::DIM_W'(band);
  assign w_m_halo = w_eff - halo_d;
  assign h_m_halo = h_eff - halo_d;
  assign w_m_band = w_eff - band_d;
  assign h_m_band = h_eff - band_d;

  // target cell sits one row above the arriving cell
  assign tr    = row_r - jsr_pkg::ROW_W'(1);
  assign tr_d  = jsr_pkg::DIM_W'(tr);
  assign col_d = jsr_pkg::DIM_W'(col_r);

  assign geom_ok = (w_eff > band_d) && (h_eff > band_d) && (row_r != '0);
  assign in_core = (tr_d >= halo_d) && (tr_d < h_m_halo) &&
                   (col_d >= halo_d) && (col_d < w_m_halo);
  assign in_band = (tr_d < band_d) || (col_d < band_d) ||
                   (tr_d >= h_m_band) || (col_d >= w_m_band);

  always_comb begin
    unique case (region_r)
      jsr_pkg::REGION_INTERIOR: begin
        sel_ok   = ~in_band;
        last_row = h_m_band - jsr_pkg::DIM_W'(1);
        last_col = w_m_band - jsr_pkg::DIM_W'(1);
      end
      jsr_pkg::REGION_BAND: begin
        sel_ok   = in_band;
        last_row = h_m_halo - jsr_pkg::DIM_W'(1);
        last_col = w_m_halo - jsr_pkg::DIM_W'(1);
      end
      default: begin
        sel_ok   = 1'b1;
        last_row = h_m_halo - jsr_pkg::DIM_W'(1);
        last_col = w_m_halo - jsr_pkg::DIM_W'(1);
      end
    endcase
  end

  // raster advance
  assign col_inc  = col_d + jsr_pkg::DIM_W'(1);
  assign row_inc  = jsr_pkg::DIM_W'(row_r) + jsr_pkg::DIM_W'(1);
  assign col_wrap = (col_inc >= w_eff);
  assign col_step = col_wrap ? '0 : col_inc[jsr_pkg::COL_W-1:0];

  always_comb begin
    if (!col_wrap) begin
      row_step = row_r;
    end else if (row_inc >= h_eff) begin
      row_step = '0;
    end else begin
      row_step = row_inc[jsr_pkg::ROW_W-1:0];
    end
  end

  always_comb begin
    q_item.cell_value = in_chan.cell_value;
    q_item.col        = col_r;
    q_item.next_col   = col_step;
    q_item.row        = tr;
    q_item.take       = geom_ok & in_core & sel_ok;
    q_item.last       = (tr_d == last_row) && (col_d == last_col);
  end

  always_comb begin
    grid_width_nxt  = grid_width_r;
    grid_height_nxt = grid_height_r;
    halo_width_nxt  = halo_width_r;
    region_nxt      = region_r;
    cfg_hit         = 1'b0;
    if (cfg_wr) begin
      unique case (cfg_chan.index)
        jsr_pkg::REG_GRID_WIDTH: begin
          grid_width_nxt = cfg_chan.data[jsr_pkg::DIM_W-1:0];
          cfg_hit        = 1'b1;
        end
        jsr_pkg::REG_GRID_HEIGHT: begin
          grid_height_nxt = cfg_chan.data[jsr_pkg::DIM_W-1:0];
          cfg_hit         = 1'b1;
        end
        jsr_pkg::REG_HALO_WIDTH: begin
          halo_width_nxt = cfg_chan.data[jsr_pkg::HALO_W-1:0];
          cfg_hit        = 1'b1;
        end
        jsr_pkg::REG_REGION_SELECT: begin
          region_nxt = cfg_chan.data[jsr_pkg::REGION_W-1:0];
          cfg_hit    = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
    if (cfg_hit) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (accept) begin
      row_nxt = row_step;
      col_nxt = col_step;
    end else begin
      row_nxt = row_r;
      col_nxt = col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= jsr_pkg::DIM_W'(jsr_pkg::MAX_WIDTH);
      grid_height_r <= jsr_pkg::DIM_W'(jsr_pkg::MAX_HEIGHT);
      halo_width_r  <= jsr_pkg::HALO_W'(1);
      region_r      <= jsr_pkg::REGION_BOTH;
      row_r         <= '0;
      col_r         <= '0;
    end else begin
      grid_width_r  <= grid_width_nxt;
      grid_height_r <= grid_height_nxt;
      halo_width_r  <= halo_width_nxt;
      region_r      <= region_nxt;
      row_r         <= row_nxt;
      col_r         <= col_nxt;
    end
  end

endmodule

FILE: hw/rtl/jsr_queue.sv
// ---------------------------------------------------------------------------
// jsr_queue
// short register fifo of classified cells between front and back
// ---------------------------------------------------------------------------
module jsr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  jsr_pkg::jsr_item_t  push_item,
  input  logic                pop,
  output jsr_pkg::jsr_item_t  pop_item,
  output jsr_pkg::jsr_qstat_t stat
);

  jsr_pkg::jsr_item_t          slot_r [jsr_pkg::QUEUE_DEPTH];
  logic [jsr_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [jsr_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [jsr_pkg::QPTR_W:0]    count_r, count_nxt;

  assign stat.full  = (count_r == (jsr_pkg::QPTR_W+1)'(jsr_pkg::QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign pop_item   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + jsr_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + jsr_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (jsr_pkg::QPTR_W+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (jsr_pkg::QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: hw/rtl/jsr_back.sv
// ---------------------------------------------------------------------------
// jsr_back
// line stores, neighbour gathering, four-point sum and output register
// ---------------------------------------------------------------------------
module jsr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  jsr_pkg::jsr_qstat_t q_stat,
  input  jsr_pkg::jsr_item_t  q_item,
  output logic                q_pop,
  jsr_out_if.source           out_chan
);

  localparam int SUM_W = jsr_pkg::DATA_W + 2;

  logic [jsr_pkg::DATA_W-1:0] up_rdata, mid_rdata;
  logic [jsr_pkg::DATA_W-1:0] south_r, west_r, prev_centre_r;
  logic                       sb_valid_r, sb_valid_nxt;
  logic                       sb_take_r, sb_last_r;
  logic [jsr_pkg::ROW_W-1:0]  sb_row_r;
  logic [jsr_pkg::COL_W-1:0]  sb_col_r;
  logic                       sb_adv, out_load;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SUM_W-1:0]    sum;

  assign sb_adv   = sb_valid_r & (~sb_take_r | ~out_valid_r | out_chan.ready);
  assign q_pop    = ~q_stat.empty & (~sb_valid_r | sb_adv);
  assign out_load = sb_adv & sb_take_r;

  // upper store takes the old middle entry, middle store the new cell
  jsr_ram #(
    .WIDTH (jsr_pkg::DATA_W),
    .DEPTH (jsr_pkg::MAX_WIDTH)
  ) u_upper_line (
    .clk     (clk),
    .wr_en   (q_pop),
    .wr_addr (q_item.col),
    .wr_data (mid_rdata),
    .rd_en   (q_pop),
    .rd_addr (q_item.col),
    .rd_data (up_rdata)
  );

  // middle store is read one column ahead: east now, centre on the next cell
  jsr_ram #(
    .WIDTH (jsr_pkg::DATA_W),
    .DEPTH (jsr_pkg::MAX_WIDTH)
  ) u_middle_line (
    .clk     (clk),
    .wr_en   (q_pop),
    .wr_addr (q_item.col),
    .wr_data (q_item.cell_value),
    .rd_en   (q_pop),
    .rd_addr (q_item.next_col),
    .rd_data (mid_rdata)
  );

  assign sum = {{2{up_rdata[jsr_pkg::DATA_W-1]}}, up_rdata}
             + {{2{south_r[jsr_pkg::DATA_W-1]}}, south_r}
             + {{2{west_r[jsr_pkg::DATA_W-1]}}, west_r}
             + {{2{mid_rdata[jsr_pkg::DATA_W-1]}}, mid_rdata};

  assign sb_valid_nxt  = q_pop | (sb_valid_r & ~sb_adv);
  assign out_valid_nxt = out_load | (out_valid_r & ~out_chan.ready);
  assign out_chan.valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      south_r       <= q_item.cell_value;
      west_r        <= prev_centre_r;
      prev_centre_r <= mid_rdata;
      sb_take_r     <= q_item.take;
      sb_last_r     <= q_item.last;
      sb_row_r      <= q_item.row;
      sb_col_r      <= q_item.col;
    end
    if (out_load) begin
      out_chan.result_value  <= sum[SUM_W-1:2];
      out_chan.row_index     <= sb_row_r;
      out_chan.col_index     <= sb_col_r;
      out_chan.last_of_frame <= sb_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sb_valid_r  <= sb_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
